// ===== src/rau_pkg.sv =====
// Package for the rational arithmetic unit.
// Holds the default word width, operation codes and status codes.
// No dependencies.
package rau_pkg;

    localparam int WIDTH_DEF = 32;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_OVF     = 2'd2;
    localparam logic [1:0] ST_ZERODEN = 2'd3;

endpackage

// ===== src/rau_div.sv =====
// Bit-serial restoring divider for unsigned words, one quotient bit per cycle.
// Used by the rational arithmetic unit; depends on no package.
module rau_div #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quot,
    output logic [WIDTH-1:0] rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] quot_reg, quot_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   shifted;

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg[WIDTH-1:0], quot_reg[WIDTH-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = CW'(WIDTH);
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
        end
        else if (run_reg)
        begin
            if (!trial[WIDTH])
            begin
                rem_next  = trial;
                quot_next = {quot_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                quot_next = {quot_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[WIDTH-1:0];

endmodule

// ===== src/rational_arith_unit_core.sv =====
// Top level of the rational arithmetic unit: sequencer, shared multiplier and
// reduction by Euclidean gcd. Depends on rau_pkg and rau_div.
//
// Channel   Direction  Handshake            Payload
// command   in         start, busy          op, a_num, a_den, b_num, b_den
// result    out        valid (one cycle)    res_num, res_den, status
//
// A word takes a data-dependent time: sequencing states plus the passes of the
// shared serial divider. One gcd reduction needs one pass per Euclid step and
// two more for the quotients; subtract and divide need two reductions. Reset
// clears the sequencer. The result cannot be stalled.
module rational_arith_unit_core #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              op,
    input  logic signed [WIDTH-1:0] a_num,
    input  logic signed [WIDTH-1:0] a_den,
    input  logic signed [WIDTH-1:0] b_num,
    input  logic signed [WIDTH-1:0] b_den,
    output logic                    valid,
    output logic signed [WIDTH-1:0] res_num,
    output logic [WIDTH-2:0]        res_den,
    output logic [1:0]              status
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_ADDL  = 5'd2;
    localparam logic [4:0] S_ADDR  = 5'd3;
    localparam logic [4:0] S_ADDD  = 5'd4;
    localparam logic [4:0] S_ADDE  = 5'd5;
    localparam logic [4:0] S_MULN  = 5'd6;
    localparam logic [4:0] S_MULD  = 5'd7;
    localparam logic [4:0] S_MULE  = 5'd8;
    localparam logic [4:0] S_GCD   = 5'd9;
    localparam logic [4:0] S_GCDW  = 5'd10;
    localparam logic [4:0] S_G     = 5'd11;
    localparam logic [4:0] S_QN    = 5'd12;
    localparam logic [4:0] S_QD    = 5'd13;
    localparam logic [4:0] S_FIN   = 5'd14;
    localparam logic [4:0] S_OUT   = 5'd15;

    localparam logic [1:0] RET_ADD = 2'd0;
    localparam logic [1:0] RET_MUL = 2'd1;
    localparam logic [1:0] RET_OUT = 2'd2;

    localparam logic [WIDTH-1:0]   MAX_W  = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic [WIDTH-1:0]   MINMAG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [2*WIDTH-1:0] MAX_P  = {{(WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};

    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] x);
        mag = x[WIDTH-1] ? (~x + 1'b1) : x;
    endfunction

    logic [4:0]              state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic [1:0]              ret_reg, ret_next;
    logic signed [WIDTH-1:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [WIDTH-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic signed [WIDTH-1:0] l_reg, l_next, s_reg, s_next;
    logic [2*WIDTH-1:0]      p_mag_reg, p_mag_next;
    logic                    p_neg_reg, p_neg_next;
    logic [WIDTH-1:0]        mn_reg, mn_next, md_reg, md_next;
    logic                    nneg_reg, nneg_next, dneg_reg, dneg_next;
    logic [WIDTH-1:0]        x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic                    valid_reg, valid_next;
    logic signed [WIDTH-1:0] rn_reg, rn_next;
    logic [WIDTH-2:0]        rd_reg, rd_next;
    logic [1:0]              st_reg, st_next;

    logic [WIDTH-1:0] mul_x, mul_y;
    logic             p_ok;
    logic [WIDTH-1:0] p_val;
    logic [WIDTH:0]   sum;
    logic             sum_ok;
    logic             div_start, div_done;
    logic [WIDTH-1:0] div_a, div_b, div_q, div_r;
    logic             fin_neg, fin_ok;
    logic [WIDTH-1:0] fin_md, fin_val;

    rau_div #(.WIDTH(WIDTH)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        case (state_reg)
            S_ADDL:  begin mul_x = an_reg; mul_y = bd_reg; end
            S_ADDR:  begin mul_x = bn_reg; mul_y = ad_reg; end
            S_MULN:  begin mul_x = an_reg; mul_y = bn_reg; end
            default: begin mul_x = ad_reg; mul_y = bd_reg; end
        endcase
        p_mag_next = {{WIDTH{1'b0}}, mag(mul_x)} * {{WIDTH{1'b0}}, mag(mul_y)};
        p_neg_next = mul_x[WIDTH-1] ^ mul_y[WIDTH-1];
        p_ok   = p_mag_reg <= (MAX_P + {{(2*WIDTH-1){1'b0}}, p_neg_reg});
        p_val  = p_neg_reg ? (~p_mag_reg[WIDTH-1:0] + 1'b1) : p_mag_reg[WIDTH-1:0];
        sum    = {l_reg[WIDTH-1], l_reg} + {p_val[WIDTH-1], p_val};
        sum_ok = sum[WIDTH] == sum[WIDTH-1];
        fin_neg = (mn_reg != '0) && (nneg_reg != dneg_reg);
        fin_md  = (mn_reg == '0) ? {{(WIDTH-1){1'b0}}, 1'b1} : md_reg;
        fin_ok  = (fin_md <= MAX_W) && (fin_neg ? (mn_reg <= MINMAG) : (mn_reg <= MAX_W));
        fin_val = fin_neg ? (~mn_reg + 1'b1) : mn_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ret_next   = ret_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        l_next     = l_reg;
        s_next     = s_reg;
        mn_next    = mn_reg;
        md_next    = md_reg;
        nneg_next  = nneg_reg;
        dneg_next  = dneg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        g_next     = g_reg;
        valid_next = 1'b0;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        st_next    = st_reg;
        div_start  = 1'b0;
        div_a      = x_reg;
        div_b      = y_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    an_next    = a_num;
                    ad_next    = a_den;
                    bn_next    = b_num;
                    bd_next    = b_den;
                    st_next    = rau_pkg::ST_OK;
                    rn_next    = '0;
                    rd_next    = {{(WIDTH-2){1'b0}}, 1'b1};
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ret_next = RET_OUT;
                if (ad_reg == '0 || bd_reg == '0)
                begin
                    st_next    = rau_pkg::ST_ZERODEN;
                    state_next = S_OUT;
                end
                else if (op_reg == rau_pkg::OP_DIV && bn_reg == '0)
                begin
                    st_next    = rau_pkg::ST_DIVZERO;
                    state_next = S_OUT;
                end
                else
                begin
                    case (op_reg)
                        rau_pkg::OP_ADD: state_next = S_ADDL;
                        rau_pkg::OP_SUB:
                        begin
                            if (bn_reg == MINMAG)
                            begin
                                st_next    = rau_pkg::ST_OVF;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                mn_next    = mag(bn_reg);
                                nneg_next  = ~bn_reg[WIDTH-1];
                                md_next    = mag(bd_reg);
                                dneg_next  = bd_reg[WIDTH-1];
                                x_next     = mag(bn_reg);
                                y_next     = mag(bd_reg);
                                ret_next   = RET_ADD;
                                state_next = S_GCD;
                            end
                        end
                        rau_pkg::OP_MUL: state_next = S_MULN;
                        default:
                        begin
                            mn_next    = mag(bd_reg);
                            nneg_next  = bd_reg[WIDTH-1];
                            md_next    = mag(bn_reg);
                            dneg_next  = bn_reg[WIDTH-1];
                            x_next     = mag(bd_reg);
                            y_next     = mag(bn_reg);
                            ret_next   = RET_MUL;
                            state_next = S_GCD;
                        end
                    endcase
                end
            end
            S_ADDL:
            begin
                ret_next   = RET_OUT;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                l_next     = p_val;
                state_next = p_ok ? S_ADDD : S_OUT;
                if (!p_ok)
                begin
                    st_next = rau_pkg::ST_OVF;
                end
            end
            S_ADDD:
            begin
                s_next     = sum[WIDTH-1:0];
                state_next = (p_ok && sum_ok) ? S_ADDE : S_OUT;
                if (!(p_ok && sum_ok))
                begin
                    st_next = rau_pkg::ST_OVF;
                end
            end
            S_ADDE:
            begin
                mn_next    = mag(s_reg);
                nneg_next  = s_reg[WIDTH-1];
                md_next    = mag(p_val);
                dneg_next  = p_val[WIDTH-1];
                x_next     = mag(s_reg);
                y_next     = mag(p_val);
                state_next = p_ok ? S_GCD : S_OUT;
                if (!p_ok)
                begin
                    st_next = rau_pkg::ST_OVF;
                end
            end
            S_MULN:
            begin
                ret_next   = RET_OUT;
                state_next = (an_reg == '0 || bn_reg == '0) ? S_OUT : S_MULD;
            end
            S_MULD:
            begin
                s_next     = p_val;
                state_next = p_ok ? S_MULE : S_OUT;
                if (!p_ok)
                begin
                    st_next = rau_pkg::ST_OVF;
                end
            end
            S_MULE:
            begin
                mn_next    = mag(s_reg);
                nneg_next  = s_reg[WIDTH-1];
                md_next    = mag(p_val);
                dneg_next  = p_val[WIDTH-1];
                x_next     = mag(s_reg);
                y_next     = mag(p_val);
                state_next = p_ok ? S_GCD : S_OUT;
                if (!p_ok)
                begin
                    st_next = rau_pkg::ST_OVF;
                end
            end
            S_GCD:
            begin
                if (y_reg == '0)
                begin
                    state_next = S_G;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_GCDW;
                end
            end
            S_GCDW:
            begin
                if (div_done)
                begin
                    x_next     = y_reg;
                    y_next     = div_r;
                    state_next = S_GCD;
                end
            end
            S_G:
            begin
                g_next     = (x_reg == '0) ? {{(WIDTH-1){1'b0}}, 1'b1} : x_reg;
                div_a      = mn_reg;
                div_b      = g_next;
                div_start  = 1'b1;
                state_next = S_QN;
            end
            S_QN:
            begin
                div_a = md_reg;
                div_b = g_reg;
                if (div_done)
                begin
                    mn_next    = div_q;
                    div_start  = 1'b1;
                    state_next = S_QD;
                end
            end
            S_QD:
            begin
                if (div_done)
                begin
                    md_next    = div_q;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!fin_ok)
                begin
                    st_next    = rau_pkg::ST_OVF;
                    state_next = S_OUT;
                end
                else
                begin
                    case (ret_reg)
                        RET_ADD:
                        begin
                            bn_next    = fin_val;
                            bd_next    = fin_md;
                            state_next = S_ADDL;
                        end
                        RET_MUL:
                        begin
                            bn_next    = fin_val;
                            bd_next    = fin_md;
                            state_next = S_MULN;
                        end
                        default:
                        begin
                            rn_next    = fin_val;
                            rd_next    = fin_md[WIDTH-2:0];
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (st_reg != rau_pkg::ST_OK)
                begin
                    rn_next = '0;
                    rd_next = {{(WIDTH-2){1'b0}}, 1'b1};
                end
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        ret_reg   <= ret_next;
        an_reg    <= an_next;
        ad_reg    <= ad_next;
        bn_reg    <= bn_next;
        bd_reg    <= bd_next;
        l_reg     <= l_next;
        s_reg     <= s_next;
        p_mag_reg <= p_mag_next;
        p_neg_reg <= p_neg_next;
        mn_reg    <= mn_next;
        md_reg    <= md_next;
        nneg_reg  <= nneg_next;
        dneg_reg  <= dneg_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        g_reg     <= g_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        st_reg    <= st_next;
    end

    assign busy    = state_reg != S_IDLE;
    assign valid   = valid_reg;
    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign status  = st_reg;

endmodule

// ===== src/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arith_unit_core.
module rau_checker #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    valid,
    input logic signed [WIDTH-1:0] res_num,
    input logic [WIDTH-2:0]        res_den,
    input logic [1:0]              status
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a word was taken");

    a_valid_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !busy)
        else $error("result strobe while busy");

    a_fell_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid)
        else $error("busy fell without a result");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && status != rau_pkg::ST_OK) |-> (res_num == '0 && res_den == 1))
        else $error("error result is not 0/1");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> res_den != '0)
        else $error("zero result denominator");

endmodule

bind rational_arith_unit_core rau_checker #(.WIDTH(WIDTH)) u_rau_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .valid   (valid),
    .res_num (res_num),
    .res_den (res_den),
    .status  (status)
);
